[sv/ahd_pkg.sv]
// types and constants for the ascii header deframer
// used by ahd_parse and ascii_header_deframer_top; no dependencies
package ahd_pkg;

    localparam logic [2:0] EV_TAKEN   = 3'd0;
    localparam logic [2:0] EV_DONE    = 3'd1;
    localparam logic [2:0] EV_BAD     = 3'd2;
    localparam logic [2:0] EV_DELIVER = 3'd3;
    localparam logic [2:0] EV_DISCARD = 3'd4;

    localparam logic [1:0] TYPE_CONV = 2'd0;
    localparam logic [1:0] TYPE_ACK  = 2'd1;
    localparam logic [1:0] TYPE_KEEP = 2'd2;

    localparam logic [7:0] CHAR_C    = 8'h43;
    localparam logic [7:0] CHAR_A    = 8'h41;
    localparam logic [7:0] CHAR_K    = 8'h4B;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    localparam logic [3:0]  HDR_LAST_POS = 4'd8;
    localparam logic [3:0]  HDR_NUM_END  = 4'd4;
    localparam logic [13:0] HDR_LEN      = 14'd9;

    typedef struct packed {
        logic [3:0]  hdr_pos;
        logic [1:0]  type_held;
        logic [13:0] num_acc;
        logic [13:0] len_acc;
        logic [13:0] remaining;
        logic        deliver;
    } t_state;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [1:0]  frame_type;
        logic [13:0] frame_number;
        logic [13:0] payload_length;
        logic [7:0]  data_byte;
        logic        matched;
        logic        last;
    } t_result;

endpackage

[sv/ascii_header_deframer_top.sv]
// ascii header deframer: input byte register, parse logic, result register
// the parse result is registered; throughput 1 item per cycle while i_out_stall does not hold the output
// each byte is parsed against the state left by the previous byte in the single state register
// reset (synchronous, active low) clears frame state, expected length and both valids
// depends on ahd_pkg and ahd_parse
module ascii_header_deframer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [13:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_event_res,
    output logic [1:0]  o_frame_type,
    output logic [13:0] o_frame_number,
    output logic [13:0] o_payload_length,
    output logic [7:0]  o_data_byte,
    output logic        o_matched,
    output logic        o_last
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic [13:0]      r_expected_length;
    ahd_pkg::t_state  r_state;
    ahd_pkg::t_state  n_state;
    ahd_pkg::t_result r_result;
    ahd_pkg::t_result n_result;
    logic             r_out_valid;
    logic             advance;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;

    ahd_parse u_parse (
        .i_state           (r_state),
        .i_byte            (r_in_byte),
        .i_expected_length (r_expected_length),
        .o_state           (n_state),
        .o_result          (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid        <= 1'b0;
            r_out_valid       <= 1'b0;
            r_expected_length <= 14'd0;
            r_state           <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_expected_length <= i_cfg_wr_data;
            end
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
                r_in_byte  <= i_rx_byte;
            end
            if (advance) begin
                r_state     <= n_state;
                r_result    <= n_result;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_event_res      = r_result.event_res;
    assign o_frame_type     = r_result.frame_type;
    assign o_frame_number   = r_result.frame_number;
    assign o_payload_length = r_result.payload_length;
    assign o_data_byte      = r_result.data_byte;
    assign o_matched        = r_result.matched;
    assign o_last           = r_result.last;

endmodule

[sv/ahd_parse.sv]
// next-state and result logic for one received byte
// depends on ahd_pkg
module ahd_parse (
    input  ahd_pkg::t_state  i_state,
    input  logic [7:0]       i_byte,
    input  logic [13:0]      i_expected_length,
    output ahd_pkg::t_state  o_state,
    output ahd_pkg::t_result o_result
);

    always_comb begin
        ahd_pkg::t_state  n;
        ahd_pkg::t_result r;
        logic [13:0]      digit;
        logic [13:0]      len_new;
        logic             is_digit;

        n        = i_state;
        r        = '0;
        r.event_res = ahd_pkg::EV_TAKEN;
        digit    = {10'd0, i_byte[3:0]};
        is_digit = (i_byte >= ahd_pkg::CHAR_ZERO) && (i_byte <= ahd_pkg::CHAR_NINE);
        len_new  = {i_state.len_acc[10:0], 3'b000} + {i_state.len_acc[12:0], 1'b0} + digit;

        if (i_state.remaining != 14'd0) begin
            r.event_res      = i_state.deliver ? ahd_pkg::EV_DELIVER : ahd_pkg::EV_DISCARD;
            r.data_byte      = i_byte;
            r.payload_length = i_state.len_acc;
            r.matched        = i_state.deliver;
            n.remaining      = i_state.remaining - 14'd1;
            r.last           = (i_state.remaining == 14'd1);
        end else if (i_state.hdr_pos == 4'd0 || i_state.hdr_pos > ahd_pkg::HDR_LAST_POS) begin
            n.hdr_pos = 4'd0;
            if (i_byte == ahd_pkg::CHAR_C || i_byte == ahd_pkg::CHAR_A ||
                i_byte == ahd_pkg::CHAR_K) begin
                n.type_held = (i_byte == ahd_pkg::CHAR_C) ? ahd_pkg::TYPE_CONV :
                              (i_byte == ahd_pkg::CHAR_A) ? ahd_pkg::TYPE_ACK :
                                                            ahd_pkg::TYPE_KEEP;
                n.num_acc = 14'd0;
                n.len_acc = 14'd0;
                n.deliver = 1'b0;
                n.hdr_pos = 4'd1;
            end else begin
                r.event_res = ahd_pkg::EV_BAD;
            end
        end else if (!is_digit) begin
            r.event_res = ahd_pkg::EV_BAD;
            n.hdr_pos   = 4'd0;
        end else if (i_state.hdr_pos <= ahd_pkg::HDR_NUM_END) begin
            n.num_acc = {i_state.num_acc[10:0], 3'b000} + {i_state.num_acc[12:0], 1'b0}
                        + digit;
            n.hdr_pos = i_state.hdr_pos + 4'd1;
        end else begin
            n.len_acc = len_new;
            if (i_state.hdr_pos < ahd_pkg::HDR_LAST_POS) begin
                n.hdr_pos = i_state.hdr_pos + 4'd1;
            end else begin
                n.hdr_pos = 4'd0;
                if (len_new < ahd_pkg::HDR_LEN) begin
                    r.event_res = ahd_pkg::EV_BAD;
                end else begin
                    n.len_acc        = len_new - ahd_pkg::HDR_LEN;
                    n.deliver        = (i_state.type_held == ahd_pkg::TYPE_CONV) &&
                                       (n.len_acc == i_expected_length);
                    n.remaining      = n.len_acc;
                    r.event_res      = ahd_pkg::EV_DONE;
                    r.payload_length = n.len_acc;
                    r.matched        = n.deliver;
                    r.last           = (n.len_acc == 14'd0);
                end
            end
        end

        r.frame_type   = n.type_held;
        r.frame_number = n.num_acc;
        o_state        = n;
        o_result       = r;
    end

endmodule
